/* src/mrbvt_pkg.sv */
// Package with the word types, record type and constants of the byte variation tracker.
`default_nettype none

package mrbvt_pkg;

  localparam int OFFSET_W = 9;
  localparam int VALUE_W  = 8;
  localparam int COUNT_W  = 8;
  localparam int TOTAL_W  = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic MODE_BASELINE = 1'b0;
  localparam logic MODE_LATER    = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [VALUE_W-1:0]  first_value;
    logic [VALUE_W-1:0]  low_value;
    logic [VALUE_W-1:0]  high_value;
    logic [COUNT_W-1:0]  reads_seen;
    logic [COUNT_W-1:0]  changes_seen;
    logic                byte_fuzzy;
    logic [TOTAL_W-1:0]  fuzzy_total;
    logic                protected_flag;
  } out_t;

  typedef struct packed {
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] low_value;
    logic [VALUE_W-1:0] high_value;
    logic [COUNT_W-1:0] reads;
    logic [COUNT_W-1:0] changes;
    logic               fuzzy;
  } rec_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

/* src/mrbvt_update.sv */
// Record update for one byte position and the running fuzzy-byte total.
`default_nettype none

module mrbvt_update (
  input  mrbvt_pkg::in_t                    item,
  input  logic                              in_range,
  input  mrbvt_pkg::rec_t                   old_rec,
  input  logic [mrbvt_pkg::TOTAL_W-1:0]     total,
  output mrbvt_pkg::rec_t                   new_rec,
  output logic [mrbvt_pkg::TOTAL_W-1:0]     total_new
);
  import mrbvt_pkg::*;

  always_comb begin
    new_rec   = old_rec;
    total_new = total;
    if (in_range) begin
      if (item.mode == MODE_BASELINE) begin
        if (item.offset == '0) begin
          total_new = '0;
        end
        new_rec.first_value = item.value;
        new_rec.low_value   = item.value;
        new_rec.high_value  = item.value;
        new_rec.reads       = COUNT_W'(1);
        new_rec.changes     = COUNT_W'(1);
        new_rec.fuzzy       = 1'b0;
      end else begin
        new_rec.reads = sat_inc(old_rec.reads);
        if (item.value < old_rec.low_value) begin
          new_rec.low_value = item.value;
          new_rec.changes   = sat_inc(new_rec.changes);
        end
        if (item.value > old_rec.high_value) begin
          new_rec.high_value = item.value;
          new_rec.changes    = sat_inc(new_rec.changes);
        end
        if ((new_rec.low_value != new_rec.high_value) && !old_rec.fuzzy) begin
          new_rec.fuzzy = 1'b1;
          if (total != TOTAL_MAX) begin
            total_new = total + TOTAL_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/multi_read_byte_variation_tracker_core.sv */
// Top level of the byte variation tracker: record memory, read-modify-write pipeline, output.
// A word accepted at the input is registered in the second stage, then in the output register.
// Throughput: one word per cycle unless the output stalls. The record memory is read on acceptance,
// written on leaving stage two; the last write is forwarded when consecutive words hit the same position.
// Reset clears the fuzzy-byte total and all valid flags; the record memory is not cleared.
`default_nettype none

module multi_read_byte_variation_tracker_core #(
  parameter int SECTOR_BYTES = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrbvt_pkg::in_t    in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output mrbvt_pkg::out_t   out_word
);
  import mrbvt_pkg::*;

  localparam int AW = $clog2(SECTOR_BYTES);
  localparam int CW = (AW + 1 > OFFSET_W) ? AW + 1 : OFFSET_W;
  localparam logic [CW-1:0] LIMIT = CW'(SECTOR_BYTES);

  rec_t mem [0:SECTOR_BYTES-1];

  logic               s2_valid_r;
  in_t                s2_item_r;
  logic               s2_in_range_r;
  rec_t               rd_rec_r;
  logic               fwd_hit_r;
  rec_t               fwd_rec_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_t               out_word_r;
  out_t               out_word_nxt;

  logic [CW-1:0] in_off_w;
  logic [CW-1:0] s2_off_w;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] s2_addr;
  logic          in_range;
  logic          accept;
  logic          s2_fire;
  logic          wr_en;
  rec_t          old_rec;
  rec_t          new_rec;

  assign in_off_w = CW'(in_word.offset);
  assign s2_off_w = CW'(s2_item_r.offset);
  assign in_addr  = in_off_w[AW-1:0];
  assign s2_addr  = s2_off_w[AW-1:0];
  assign in_range = in_off_w < LIMIT;

  assign s2_fire  = s2_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s2_valid_r && !s2_fire;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = s2_fire && s2_in_range_r;
  assign old_rec  = fwd_hit_r ? fwd_rec_r : rd_rec_r;

  mrbvt_update u_update (
    .item      (s2_item_r),
    .in_range  (s2_in_range_r),
    .old_rec   (old_rec),
    .total     (total_r),
    .new_rec   (new_rec),
    .total_new (total_nxt)
  );

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      rd_rec_r <= mem[in_addr];
    end
    if (wr_en) begin
      mem[s2_addr] <= new_rec;
    end
  end

  always_comb begin
    out_word_nxt                = '0;
    out_word_nxt.byte_offset    = s2_item_r.offset;
    if (s2_in_range_r) begin
      out_word_nxt.first_value  = new_rec.first_value;
      out_word_nxt.low_value    = new_rec.low_value;
      out_word_nxt.high_value   = new_rec.high_value;
      out_word_nxt.reads_seen   = new_rec.reads;
      out_word_nxt.changes_seen = new_rec.changes;
      out_word_nxt.byte_fuzzy   = new_rec.fuzzy;
    end
    out_word_nxt.fuzzy_total    = total_nxt;
    out_word_nxt.protected_flag = (total_nxt != '0);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s2_fire) begin
        total_r <= total_nxt;
      end
      if (accept) begin
        s2_valid_r <= 1'b1;
        fwd_hit_r  <= wr_en && (s2_addr == in_addr);
      end else if (s2_fire) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_item_r     <= in_word;
      s2_in_range_r <= in_range;
      fwd_rec_r     <= new_rec;
    end
    if (s2_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

/* src/mrbvt_checker.sv */
// Port-level checker for the byte variation tracker, bound to the top level.
`default_nettype none

module mrbvt_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input mrbvt_pkg::in_t  in_word,
  input logic            out_valid,
  input logic            out_stall,
  input mrbvt_pkg::out_t out_word
);
  import mrbvt_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output word valid after reset.");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("Input stalled while the output is free.");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_word)))
    else $error("Stalled input word changed.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("Stalled output word changed.");

  a_protected_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.protected_flag == (out_word.fuzzy_total != '0)))
    else $error("Protected flag disagrees with the fuzzy total.");

endmodule

bind multi_read_byte_variation_tracker_core mrbvt_checker u_mrbvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
